// File: hw/rtl/wfsum_pkg.sv
// Shared constants, codes and control types for the frame statistics block.
package wfsum_pkg;

    localparam int AP_SLOTS     = 64;
    localparam int CLIENT_SLOTS = 128;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 32;
    localparam int SIG_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int CLASS_W    = 2;
    localparam int KIND_W     = 3;
    localparam int AP_SEEN_W  = 7;
    localparam int CLI_SEEN_W = 8;

    localparam int AP_FILL_W  = $clog2(AP_SLOTS + 1);
    localparam int CLI_FILL_W = $clog2(CLIENT_SLOTS + 1);
    localparam int AP_ADDR_W  = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
    localparam int CLI_ADDR_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int IDX_W      = (AP_FILL_W > CLI_FILL_W) ? AP_FILL_W : CLI_FILL_W;

    localparam logic [CLASS_W-1:0] CLS_FRAME = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_EAPOL = 2'd1;

    localparam logic [KIND_W-1:0] KIND_MGMT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CTRL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EAPOL = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AP,
        ST_CLI_SRC,
        ST_CLI_DST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic search;
        logic use_ap;
        logic key_dst;
        logic snap;
    } cmd_t;

    typedef struct packed {
        logic go_ap;
        logic go_cli;
        logic search_done;
        logic out_free;
    } stat_t;

endpackage

// File: hw/rtl/wfsum_ctrl.sv
// Sequencing state machine: accept, table searches, result hand-off.
module wfsum_ctrl import wfsum_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (stat.go_ap) begin
                        state_next = ST_AP;
                    end else if (stat.go_cli) begin
                        state_next = ST_CLI_SRC;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_AP: begin
                if (stat.search_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLI_SRC: begin
                if (stat.search_done) begin
                    state_next = ST_CLI_DST;
                end
            end
            ST_CLI_DST: begin
                if (stat.search_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_AP: begin
                cmd.search = 1'b1;
                cmd.use_ap = 1'b1;
            end
            ST_CLI_SRC: begin
                cmd.search = 1'b1;
            end
            ST_CLI_DST: begin
                cmd.search  = 1'b1;
                cmd.key_dst = 1'b1;
            end
            ST_DONE: begin
                cmd.snap = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/wfsum_dp.sv
// Datapath: counters, latches, address tables with search engine, result register.
module wfsum_dp import wfsum_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic        [CLASS_W-1:0]    s_event_class,
    input  logic        [KIND_W-1:0]     s_frame_kind,
    input  logic        [ADDR_W-1:0]     s_source_address,
    input  logic        [ADDR_W-1:0]     s_dest_address,
    input  logic signed [SIG_W-1:0]      s_signal_level,
    input  logic        [CHAN_W-1:0]     s_radio_channel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [CNT_W-1:0]      m_total_frames,
    output logic        [CNT_W-1:0]      m_management_frames,
    output logic        [CNT_W-1:0]      m_control_frames,
    output logic        [CNT_W-1:0]      m_data_frames,
    output logic        [CNT_W-1:0]      m_eapol_frames,
    output logic        [AP_SEEN_W-1:0]  m_access_points_seen,
    output logic        [CLI_SEEN_W-1:0] m_clients_seen,
    output logic signed [SIG_W-1:0]      m_last_signal,
    output logic        [CHAN_W-1:0]     m_last_channel
);

    logic [ADDR_W-1:0] ap_mem  [AP_SLOTS];
    logic [ADDR_W-1:0] cli_mem [CLIENT_SLOTS];
    logic [ADDR_W-1:0] ap_rdata_reg;
    logic [ADDR_W-1:0] cli_rdata_reg;

    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] dst_reg;

    logic [CNT_W-1:0] total_reg, mgmt_reg, ctrl_reg, data_reg, eapol_reg;
    logic signed [SIG_W-1:0] sig_reg;
    logic [CHAN_W-1:0]       chan_reg;

    logic [AP_FILL_W-1:0]  ap_fill_reg;
    logic [AP_FILL_W-1:0]  ap_fill_next;
    logic [CLI_FILL_W-1:0] cli_fill_reg;
    logic [CLI_FILL_W-1:0] cli_fill_next;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             pend_reg;
    logic             pend_next;

    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_total_reg, m_mgmt_reg, m_ctrl_reg, m_data_reg, m_eapol_reg;
    logic [AP_SEEN_W-1:0]    m_ap_reg;
    logic [CLI_SEEN_W-1:0]   m_cli_reg;
    logic signed [SIG_W-1:0] m_sig_reg;
    logic [CHAN_W-1:0]       m_chan_reg;

    logic              counted;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] rdata;
    logic [IDX_W-1:0]  fill_sel;
    logic              full;
    logic              found;
    logic              exhausted;
    logic              done;
    logic              issue;
    logic              store;
    logic              ap_we;
    logic              cli_we;

    assign counted = (s_event_class == CLS_FRAME) || (s_event_class == CLS_EAPOL);

    assign key      = cmd.key_dst ? dst_reg : src_reg;
    assign rdata    = cmd.use_ap ? ap_rdata_reg : cli_rdata_reg;
    assign fill_sel = cmd.use_ap ? IDX_W'(ap_fill_reg) : IDX_W'(cli_fill_reg);
    assign full     = cmd.use_ap ? (ap_fill_reg == AP_FILL_W'(AP_SLOTS))
                                 : (cli_fill_reg == CLI_FILL_W'(CLIENT_SLOTS));

    // the read issued last cycle is compared now; index at fill means all issued
    assign found     = pend_reg && (rdata == key);
    assign exhausted = (idx_reg == fill_sel);
    assign done      = full || found || exhausted;
    assign issue     = cmd.search && !done;
    assign store     = cmd.search && !full && !found && exhausted;
    assign ap_we     = store && cmd.use_ap;
    assign cli_we    = store && !cmd.use_ap;

    always_comb begin
        idx_next = idx_reg;
        if (cmd.accept || (cmd.search && done)) begin
            idx_next = '0;
        end else if (issue) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign pend_next     = issue;
    assign ap_fill_next  = ap_we ? ap_fill_reg + AP_FILL_W'(1) : ap_fill_reg;
    assign cli_fill_next = cli_we ? cli_fill_reg + CLI_FILL_W'(1) : cli_fill_reg;

    always_ff @(posedge aclk) begin
        if (ap_we) begin
            ap_mem[ap_fill_reg[AP_ADDR_W-1:0]] <= key;
        end
        ap_rdata_reg <= ap_mem[idx_reg[AP_ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cli_we) begin
            cli_mem[cli_fill_reg[CLI_ADDR_W-1:0]] <= key;
        end
        cli_rdata_reg <= cli_mem[idx_reg[CLI_ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            src_reg <= s_source_address;
            dst_reg <= s_dest_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            mgmt_reg     <= '0;
            ctrl_reg     <= '0;
            data_reg     <= '0;
            eapol_reg    <= '0;
            sig_reg      <= '0;
            chan_reg     <= '0;
            ap_fill_reg  <= '0;
            cli_fill_reg <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            ap_fill_reg  <= ap_fill_next;
            cli_fill_reg <= cli_fill_next;
            if (cmd.accept && counted) begin
                total_reg <= total_reg + CNT_W'(1);
                sig_reg   <= s_signal_level;
                chan_reg  <= s_radio_channel;
                case (s_frame_kind)
                    KIND_MGMT:  mgmt_reg  <= mgmt_reg + CNT_W'(1);
                    KIND_CTRL:  ctrl_reg  <= ctrl_reg + CNT_W'(1);
                    KIND_DATA:  data_reg  <= data_reg + CNT_W'(1);
                    KIND_EAPOL: eapol_reg <= eapol_reg + CNT_W'(1);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.snap) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            m_total_reg <= total_reg;
            m_mgmt_reg  <= mgmt_reg;
            m_ctrl_reg  <= ctrl_reg;
            m_data_reg  <= data_reg;
            m_eapol_reg <= eapol_reg;
            m_ap_reg    <= AP_SEEN_W'(ap_fill_reg);
            m_cli_reg   <= CLI_SEEN_W'(cli_fill_reg);
            m_sig_reg   <= sig_reg;
            m_chan_reg  <= chan_reg;
        end
    end

    assign stat.go_ap       = counted && (s_frame_kind == KIND_MGMT);
    assign stat.go_cli      = counted && (s_frame_kind == KIND_DATA);
    assign stat.search_done = done;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid              = m_valid_reg;
    assign m_total_frames       = m_total_reg;
    assign m_management_frames  = m_mgmt_reg;
    assign m_control_frames     = m_ctrl_reg;
    assign m_data_frames        = m_data_reg;
    assign m_eapol_frames       = m_eapol_reg;
    assign m_access_points_seen = m_ap_reg;
    assign m_clients_seen       = m_cli_reg;
    assign m_last_signal        = m_sig_reg;
    assign m_last_channel       = m_chan_reg;

endmodule

// File: hw/rtl/wifi_frame_stats_unique_mac_core.sv
// Top level of the frame statistics block with unique address tables.
//
// Input channel s_*: one captured frame event per item (valid/ready).
// Result channel m_*: one snapshot of all counts per input item.
// Frame and EAPOL class events bump the counters and latch signal and channel
// at acceptance. Management frames search the access point table, data frames
// search the client table for the source and then the destination address;
// a new address is appended while the table has room.
// Each search is one registered memory read per stored entry, pipelined, and
// a full table ends it without a read. Events without a search go straight
// from acceptance to the snapshot. One item is in work at a time; s_ready is
// high only while idle, so the next item is taken only after the previous
// snapshot is registered.
// The result register lets the next item be accepted while a snapshot waits;
// a stalled receiver holds the block only when the following snapshot is ready.
// aresetn (synchronous) clears counters, latches and fill counts; table
// contents are not cleared, entries beyond the fill count are never compared.
module wifi_frame_stats_unique_mac_core import wfsum_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic        [CLASS_W-1:0]    s_event_class,
    input  logic        [KIND_W-1:0]     s_frame_kind,
    input  logic        [ADDR_W-1:0]     s_source_address,
    input  logic        [ADDR_W-1:0]     s_dest_address,
    input  logic signed [SIG_W-1:0]      s_signal_level,
    input  logic        [CHAN_W-1:0]     s_radio_channel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic        [CNT_W-1:0]      m_total_frames,
    output logic        [CNT_W-1:0]      m_management_frames,
    output logic        [CNT_W-1:0]      m_control_frames,
    output logic        [CNT_W-1:0]      m_data_frames,
    output logic        [CNT_W-1:0]      m_eapol_frames,
    output logic        [AP_SEEN_W-1:0]  m_access_points_seen,
    output logic        [CLI_SEEN_W-1:0] m_clients_seen,
    output logic signed [SIG_W-1:0]      m_last_signal,
    output logic        [CHAN_W-1:0]     m_last_channel
);

    cmd_t  cmd;
    stat_t stat;

    wfsum_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wfsum_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .s_event_class        (s_event_class),
        .s_frame_kind         (s_frame_kind),
        .s_source_address     (s_source_address),
        .s_dest_address       (s_dest_address),
        .s_signal_level       (s_signal_level),
        .s_radio_channel      (s_radio_channel),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_total_frames       (m_total_frames),
        .m_management_frames  (m_management_frames),
        .m_control_frames     (m_control_frames),
        .m_data_frames        (m_data_frames),
        .m_eapol_frames       (m_eapol_frames),
        .m_access_points_seen (m_access_points_seen),
        .m_clients_seen       (m_clients_seen),
        .m_last_signal        (m_last_signal),
        .m_last_channel       (m_last_channel)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous item still in work");

    a_snap_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.snap |-> (!m_valid || m_ready))
        else $error("snapshot overwrote a result not yet taken");

    a_valid_from_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.snap))
        else $error("result raised without a snapshot");

    a_search_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search |-> !s_ready)
        else $error("table search while input ready");

endmodule
